// File: hdl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// shared constants and types of the stereo feedback echo
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

  // configuration port
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_SAMPLES = 2'd0,
    REG_ECHO_GAIN     = 2'd1
  } cfg_reg_e;

  // register reset values
  localparam int DELAY_RESET = 1920;
  localparam int GAIN_RESET  = 52429;

  // arithmetic
  localparam int GAIN_W     = 17;     // unsigned q1.16, up to 131071
  localparam int FB_W       = 16;
  localparam int FB_Q16     = 52429;  // feedback factor 0.8 in q0.16
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;

endpackage

`default_nettype wire

// File: hdl/sfe_store.sv
// ----------------------------------------------------------------------------
// sfe_store
// delay memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_store #(
  parameter int DEPTH = 131072,
  parameter int WIDTH = 32,
  parameter int AW    = 17
) (
  input  wire logic             clk_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read before write on a shared address
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/sfe_mix.sv
// ----------------------------------------------------------------------------
// sfe_mix
// one channel of gain*x + 0.8*y, rounded and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_mix #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   x_i,
  input  wire logic signed [SAMPLE_BITS-1:0]   y_i,
  input  wire logic [sfe_pkg::GAIN_W-1:0]      gain_i,
  output logic signed      [SAMPLE_BITS-1:0]   res_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int GW = SB + sfe_pkg::GAIN_W + 1;  // gain product
  localparam int FW = SB + sfe_pkg::FB_W + 1;    // feedback product
  localparam int SW = SB + 19;                   // sum
  localparam int RW = SW - sfe_pkg::FRAC_BITS;   // rounded

  logic signed [GW-1:0] pg_d, pg_q;
  logic signed [FW-1:0] pf_d, pf_q;
  logic signed [SW-1:0] sum;
  logic signed [RW-1:0] rnd;
  logic        [RW-SB:0] top_bits;

  assign pg_d = $signed({1'b0, gain_i}) * x_i;
  assign pf_d = $signed({1'b0, sfe_pkg::FB_W'(sfe_pkg::FB_Q16)}) * y_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pg_q <= pg_d;
      pf_q <= pf_d;
    end
  end

  // round half up, then floor by the arithmetic shift
  assign sum      = SW'(pg_q) + SW'(pf_q) + SW'(sfe_pkg::ROUND_HALF);
  assign rnd      = sum[SW-1:sfe_pkg::FRAC_BITS];
  assign top_bits = rnd[RW-1:SB-1];

  always_comb begin
    if ((top_bits == '0) || (top_bits == '1)) begin
      res_o = rnd[SB-1:0];
    end else if (rnd[RW-1]) begin
      res_o = {1'b1, {(SB-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(SB-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// File: hdl/stereo_feedback_echo.sv
// ----------------------------------------------------------------------------
// stereo_feedback_echo
// stereo feedback comb delay line, wet output only
// ----------------------------------------------------------------------------
// path: an accepted frame passes the read, multiply and sum/write stages and
//   then the output register before its result reaches the master side
// throughput: one frame per cycle while the master side takes results, set by
//   the single write and read port of the delay memory; after a delay write
//   the slave side is held off while the delay is reduced modulo DEPTH
// reset: no clearing pass; a fill mark on the write index makes never
//   written entries read as zero, so the block is ready right after reset
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_feedback_echo #(
  parameter int DEPTH       = 131072,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration write port
  input  wire logic                                   cfg_we_i,
  input  wire logic [sfe_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [sfe_pkg::CFG_W-1:0]              cfg_data_i,
  // input frames
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // fields from bit 0: sample_left, sample_right
  input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  // wet results
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // fields from bit 0: out_left, out_right
  output logic      [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata_o
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = 2 * SB;                        // packed stereo word
  localparam int DW = ((2 * SB + 7) / 8) * 8;        // stream data width
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW = sfe_pkg::CFG_W;
  localparam int CW = ((AW > KW) ? AW : KW) + 1;     // index arithmetic width

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic [KW-1:0]                 delay_q;  // held modulo DEPTH once reduced
  logic [sfe_pkg::GAIN_W-1:0]    gain_q;
  logic                          busy;

  // the delay is brought below DEPTH one subtraction per cycle while no configuration write occurs
  assign busy = (CW'(delay_q) >= CW'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= KW'(sfe_pkg::DELAY_RESET % DEPTH);
      gain_q  <= sfe_pkg::GAIN_W'(sfe_pkg::GAIN_RESET);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sfe_pkg::REG_DELAY_SAMPLES: delay_q <= cfg_data_i;
        sfe_pkg::REG_ECHO_GAIN:     gain_q  <= cfg_data_i;
        default: ;  // unknown register, write dropped
      endcase
    end else if (busy) begin
      delay_q <= delay_q - KW'(DEPTH);
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline handshake
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_free, s2_free, s1_free;
  logic s_fire, s1_adv, s2_adv;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s2_free  = !s2_valid_q || out_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign s2_adv   = s2_valid_q && out_free;
  assign s1_adv   = s1_valid_q && s2_free;

  assign s_axis_tready_o = s1_free && !busy;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_q  <= s_fire;
      if (s2_free)  s2_valid_q  <= s1_valid_q;
      if (out_free) out_valid_q <= s2_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // write index, fill mark and read address
  // ---------------------------------------------------------------------------
  logic [AW-1:0] w_q;
  logic          wrapped_q;  // every entry has been claimed by a transaction
  logic [AW-1:0] rd_addr;
  logic          rd_filled;

  always_comb begin
    if (CW'(w_q) >= CW'(delay_q)) begin
      rd_addr = AW'(CW'(w_q) - CW'(delay_q));
    end else begin
      rd_addr = AW'(CW'(w_q) + CW'(DEPTH) - CW'(delay_q));
    end
  end

  // entries at or past the write index have never been written before wrap
  assign rd_filled = wrapped_q || (rd_addr < w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= '0;
      wrapped_q <= 1'b0;
    end else if (s_fire) begin
      if (w_q == AW'(DEPTH - 1)) begin
        w_q       <= '0;
        wrapped_q <= 1'b1;
      end else begin
        w_q <= w_q + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: memory read in flight
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0] s1_xl_q, s1_xr_q;
  logic [AW-1:0]        s1_w_q, s1_rd_q;
  logic                 s1_filled_q;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_xl_q     <= s_axis_tdata_i[SB-1:0];
      s1_xr_q     <= s_axis_tdata_i[PW-1:SB];
      s1_w_q      <= w_q;
      s1_rd_q     <= rd_addr;
      s1_filled_q <= rd_filled;
    end
  end

  // ---------------------------------------------------------------------------
  // delay memory, both channels side by side in one word
  // ---------------------------------------------------------------------------
  logic [PW-1:0]        mem_rdata;
  logic [AW-1:0]        s2_w_q;
  logic signed [SB-1:0] res_l, res_r;

  sfe_store #(
    .DEPTH (DEPTH),
    .WIDTH (PW),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (s_fire),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata),
    .we_i    (s2_adv),
    .waddr_i (s2_w_q),
    .wdata_i ({res_r, res_l})
  );

  // ---------------------------------------------------------------------------
  // forwarding: the two frames ahead may write after the read was issued
  // ---------------------------------------------------------------------------
  logic          lw0_valid_q, lw1_valid_q;
  logic [AW-1:0] lw0_addr_q, lw1_addr_q;
  logic [PW-1:0] lw0_data_q, lw1_data_q;
  logic [PW-1:0] y_pair;

  always_comb begin
    if (s2_valid_q && (s2_w_q == s1_rd_q)) begin
      y_pair = {res_r, res_l};       // frame ahead writes this very edge
    end else if (lw0_valid_q && (lw0_addr_q == s1_rd_q)) begin
      y_pair = lw0_data_q;
    end else if (lw1_valid_q && (lw1_addr_q == s1_rd_q)) begin
      y_pair = lw1_data_q;
    end else if (s1_filled_q) begin
      y_pair = mem_rdata;
    end else begin
      y_pair = '0;                   // never written since reset
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw0_valid_q <= 1'b0;
      lw1_valid_q <= 1'b0;
    end else if (s2_adv) begin
      lw0_valid_q <= 1'b1;
      lw1_valid_q <= lw0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      lw0_addr_q <= s2_w_q;
      lw0_data_q <= {res_r, res_l};
      lw1_addr_q <= lw0_addr_q;
      lw1_data_q <= lw0_data_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: products registered, sum and saturate feed the write
  // ---------------------------------------------------------------------------
  logic [PW-1:0] s2_y_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_w_q <= s1_w_q;
      s2_y_q <= y_pair;
    end
  end

  sfe_mix #(
    .SAMPLE_BITS (SB)
  ) u_mix_left (
    .clk_i  (clk_i),
    .en_i   (s1_adv),
    .x_i    (s1_xl_q),
    .y_i    (y_pair[SB-1:0]),
    .gain_i (gain_q),
    .res_o  (res_l)
  );

  sfe_mix #(
    .SAMPLE_BITS (SB)
  ) u_mix_right (
    .clk_i  (clk_i),
    .en_i   (s1_adv),
    .x_i    (s1_xr_q),
    .y_i    (y_pair[PW-1:SB]),
    .gain_i (gain_q),
    .res_o  (res_r)
  );

  // ---------------------------------------------------------------------------
  // output register, parts the master side from the pipeline
  // ---------------------------------------------------------------------------
  logic [PW-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_data_q <= s2_y_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DW'(out_data_q);

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> (w_q == (($past(w_q) == AW'(DEPTH - 1)) ? '0 : $past(w_q) + AW'(1))))
    else $error("write index did not step by one per transaction");

  a_delay_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> (CW'(delay_q) < CW'(DEPTH)))
    else $error("frame accepted with unreduced delay");

  a_recent_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lw0_valid_q && lw1_valid_q) |-> (lw0_addr_q != lw1_addr_q))
    else $error("two most recent writes hit the same entry");

  a_recent_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_adv |=> (lw0_valid_q && (lw0_addr_q == $past(s2_w_q))))
    else $error("forwarding register missed a memory write");

endmodule

`default_nettype wire
